### design/lprh_pkg.sv
// Shared types and constants of the predictor residual histogram unit.
`default_nettype none

package lprh_pkg;

  // Histograms per channel: the raw samples plus eight predictor residuals.
  localparam int HistPerCh = 9;
  // Bins per histogram and the width of a bin index.
  localparam int Bins = 256;
  localparam int BinW = 8;
  // Width of the step counter of the sequencer (holds up to nine steps).
  localparam int StepW = 4;
  // Width of the count field on the output.
  localparam int OutCountW = 32;
  // Width used when forming a histogram row number (rows stay below 36).
  localparam int RowCalcW = 6;

  // Operation codes of an input beat.
  typedef enum logic [0:0] {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  // Table code that sums one bin over every channel.
  localparam logic [1:0] TableSum = 2'd3;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RUN   = 4'b0100,
    S_DONE  = 4'b1000
  } seq_state_e;

  // Payload of one input beat.
  typedef struct packed {
    op_e        operation;
    logic [7:0] nw;
    logic [7:0] n;
    logic [7:0] w;
    logic [7:0] sample;
    logic [1:0] channel;
    logic [3:0] read_predictor;
    logic [1:0] read_table;
    logic [7:0] read_bin;
  } in_item_t;

  // Payload of one output beat.
  typedef struct packed {
    logic [7:0]           res_west;
    logic [7:0]           res_north;
    logic [7:0]           res_northwest;
    logic [7:0]           res_plane;
    logic [7:0]           res_half_west;
    logic [7:0]           res_half_north;
    logic [7:0]           res_average;
    logic [7:0]           res_median;
    logic [OutCountW-1:0] count;
  } out_item_t;

  // The eight residuals, index 0 for the west predictor up to 7 for the median.
  typedef logic [7:0][7:0] res_vec_t;

endpackage

`default_nettype wire

### design/lprh_if.sv
// Valid/ready channel interfaces for input and output beats.
`default_nettype none

interface lprh_in_if
  import lprh_pkg::*;
  ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lprh_out_if
  import lprh_pkg::*;
  ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/lossless_predictor_residual_histogram_unit.sv
// Top level of the predictor residual histogram unit: sequencer and output register.
`default_nettype none

// After reset the unit clears its counter memory, one counter per cycle, CHANNELS*9*256
// counters (6912 at the default of three channels); no input beat is taken meanwhile.
// An accumulate beat reads its nine counters, increments them with saturation and writes
// them back one per cycle through the single read and single write port of the counter
// memory. A read beat fetches one counter, or CHANNELS for the sum table. A read beat
// out of range, like an accumulate beat whose channel is out of range, fetches nothing.
// The result is held in an output register, so a new input beat is taken while the
// previous result still waits there.
module lossless_predictor_residual_histogram_unit
  import lprh_pkg::*;
#(
  parameter int CHANNELS   = 3,
  parameter int COUNT_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lprh_in_if.sink   in_i,
  lprh_out_if.source out_o
);

  localparam int Rows  = CHANNELS * HistPerCh;
  localparam int RowW  = $clog2(Rows);
  localparam int Depth = Rows * Bins;
  localparam int AddrW = RowW + BinW;
  localparam int OutW  = (COUNT_BITS > OutCountW) ? COUNT_BITS : OutCountW;

  seq_state_e            st_q, st_d;
  in_item_t              item_q, item_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [StepW-1:0]      nsteps_q, nsteps_d;
  logic                  pv_q;
  logic [AddrW-1:0]      pend_addr_q;
  logic [COUNT_BITS-1:0] sum_q, sum_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  res_vec_t              res;
  logic                  accept;
  logic                  issue;
  logic                  load_out;
  logic [1:0]            tab_sel;
  logic [3:0]            pidx;
  logic [RowCalcW-1:0]   row_wide;
  logic [BinW-1:0]       bin_sel;
  logic [AddrW-1:0]      mem_raddr;
  logic                  mem_we;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  store_busy;
  logic [COUNT_BITS:0]   sum_wide;
  logic [OutW-1:0]       sum_ext;
  logic [OutCountW-1:0]  count_out;

  // Residuals of the held beat.
  lprh_predict u_predict (
    .nw_i    (item_q.nw),
    .n_i     (item_q.n),
    .w_i     (item_q.w),
    .sample_i(item_q.sample),
    .res_o   (res)
  );

  // Counter memory.
  lprh_store #(
    .Depth    (Depth),
    .AddrW    (AddrW),
    .CountBits(COUNT_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (issue),
    .rd_addr_i(mem_raddr),
    .rd_data_o(mem_rdata),
    .wr_en_i  (mem_we),
    .wr_addr_i(pend_addr_q),
    .wr_data_i(mem_wdata),
    .busy_o   (store_busy)
  );

  assign in_i.ready = (st_q == S_IDLE);
  assign accept     = in_i.valid && (st_q == S_IDLE);
  assign issue      = (st_q == S_RUN) && (step_q < nsteps_q);

  // Address of the counter touched by the current step.
  always_comb begin
    if (item_q.operation == OP_ACCUM) begin
      tab_sel = item_q.channel;
      pidx    = step_q;
      if (step_q == '0) begin
        bin_sel = item_q.sample;
      end else begin
        bin_sel = res[3'(step_q - 1'b1)];
      end
    end else begin
      tab_sel = (item_q.read_table == TableSum) ? step_q[1:0] : item_q.read_table;
      pidx    = item_q.read_predictor;
      bin_sel = item_q.read_bin;
    end
  end

  assign row_wide  = RowCalcW'(tab_sel) * RowCalcW'(HistPerCh) + RowCalcW'(pidx);
  assign mem_raddr = {row_wide[RowW-1:0], bin_sel};

  // Write back the incremented counter in the cycle after its read.
  assign mem_we    = pv_q && (item_q.operation == OP_ACCUM);
  assign mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + 1'b1;

  // Saturating sum over fetched counters for read beats.
  assign sum_wide = {1'b0, sum_q} + {1'b0, mem_rdata};

  // Clamp the count to the output width.
  assign sum_ext   = OutW'(sum_q);
  assign count_out = (sum_ext > OutW'({OutCountW{1'b1}})) ? '1 : sum_ext[OutCountW-1:0];

  assign load_out = (st_q == S_DONE) && (!out_valid_q || out_o.ready);

  // Sequencer.
  always_comb begin
    st_d     = st_q;
    item_d   = item_q;
    step_d   = step_q;
    nsteps_d = nsteps_q;
    sum_d    = sum_q;
    unique case (st_q)
      S_CLEAR: begin
        if (!store_busy) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          st_d   = S_RUN;
          item_d = in_i.payload;
          step_d = '0;
          sum_d  = '0;
          if (in_i.payload.operation == OP_ACCUM) begin
            nsteps_d = ({1'b0, in_i.payload.channel} < 3'(CHANNELS)) ?
                       StepW'(HistPerCh) : '0;
          end else if (in_i.payload.read_predictor >= 4'(HistPerCh)) begin
            nsteps_d = '0;
          end else if (in_i.payload.read_table == TableSum) begin
            nsteps_d = StepW'(CHANNELS);
          end else if ({1'b0, in_i.payload.read_table} < 3'(CHANNELS)) begin
            nsteps_d = StepW'(1);
          end else begin
            nsteps_d = '0;
          end
        end
      end
      S_RUN: begin
        if (issue) begin
          step_d = step_q + 1'b1;
        end
        if (pv_q && (item_q.operation == OP_READ)) begin
          sum_d = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
        end
        if (!issue && !pv_q) begin
          st_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_CLEAR;
      end
    endcase
  end

  // Result beat for the output register.
  always_comb begin
    out_d = out_q;
    if (load_out) begin
      out_d = '0;
      if (item_q.operation == OP_ACCUM) begin
        out_d.res_west       = res[0];
        out_d.res_north      = res[1];
        out_d.res_northwest  = res[2];
        out_d.res_plane      = res[3];
        out_d.res_half_west  = res[4];
        out_d.res_half_north = res[5];
        out_d.res_average    = res[6];
        out_d.res_median     = res[7];
      end else begin
        out_d.count = count_out;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      step_q      <= '0;
      nsteps_q    <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      nsteps_q    <= nsteps_d;
      pv_q        <= issue;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    sum_q       <= sum_d;
    pend_addr_q <= mem_raddr;
    out_q       <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

`ifndef ASSERT_OFF
  // A counter is written back only in the cycle after it was read.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_we |-> $past(issue))
    else $error("write-back without a preceding read");

  // An accepted beat always starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> (st_q == S_RUN))
    else $error("accepted beat did not start the sequencer");

  // The step counter never passes the number of fetches of the beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_q <= nsteps_q)
    else $error("step counter overran");

  // A new result appears only out of the done state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   $rose(out_valid_q) |-> $past(st_q == S_DONE))
    else $error("result loaded outside the done state");

  // No beat is taken while the counter memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni) store_busy |-> !in_i.ready)
    else $error("input ready during clearing");
`endif

endmodule

`default_nettype wire

### design/lprh_predict.sv
// Eight lossless predictors and their residuals modulo 256.
`default_nettype none

module lprh_predict
  import lprh_pkg::*;
(
  input  wire logic [7:0] nw_i,
  input  wire logic [7:0] n_i,
  input  wire logic [7:0] w_i,
  input  wire logic [7:0] sample_i,
  output res_vec_t        res_o
);

  logic [7:0]        plane;
  logic signed [8:0] diff_w;
  logic signed [8:0] diff_n;
  logic signed [8:0] half_w;
  logic signed [8:0] half_n;
  logic [7:0]        pred_half_w;
  logic [7:0]        pred_half_n;
  logic [8:0]        sum_nw;
  logic [7:0]        pred_avg;
  logic [7:0]        lo;
  logic [7:0]        hi;
  logic [7:0]        pred_med;

  // Plane predictor W+N-NW wraps modulo 256.
  assign plane = w_i + n_i - nw_i;

  // Halved gradients, truncated toward zero: add one before the shift when negative.
  assign diff_w = $signed({1'b0, w_i}) - $signed({1'b0, nw_i});
  assign diff_n = $signed({1'b0, n_i}) - $signed({1'b0, nw_i});
  assign half_w = (diff_w + $signed({8'b0, diff_w[8]})) >>> 1;
  assign half_n = (diff_n + $signed({8'b0, diff_n[8]})) >>> 1;
  assign pred_half_w = n_i + half_w[7:0];
  assign pred_half_n = w_i + half_n[7:0];

  // Average of N and W, rounded down.
  assign sum_nw   = {1'b0, n_i} + {1'b0, w_i};
  assign pred_avg = sum_nw[8:1];

  // Median edge detector.
  assign lo = (n_i < w_i) ? n_i : w_i;
  assign hi = (n_i < w_i) ? w_i : n_i;
  always_comb begin
    if (nw_i >= hi) begin
      pred_med = lo;
    end else if (nw_i <= lo) begin
      pred_med = hi;
    end else begin
      pred_med = plane;
    end
  end

  // Residuals are the sample minus each prediction, modulo 256.
  assign res_o[0] = sample_i - w_i;
  assign res_o[1] = sample_i - n_i;
  assign res_o[2] = sample_i - nw_i;
  assign res_o[3] = sample_i - plane;
  assign res_o[4] = sample_i - pred_half_w;
  assign res_o[5] = sample_i - pred_half_n;
  assign res_o[6] = sample_i - pred_avg;
  assign res_o[7] = sample_i - pred_med;

endmodule

`default_nettype wire

### design/lprh_store.sv
// Histogram counter memory with one read and one write port and a clearing sweep.
`default_nettype none

module lprh_store
  import lprh_pkg::*;
#(
  parameter int Depth     = 6912,
  parameter int AddrW     = 13,
  parameter int CountBits = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rd_en_i,
  input  wire logic [AddrW-1:0]     rd_addr_i,
  output logic      [CountBits-1:0] rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [AddrW-1:0]     wr_addr_i,
  input  wire logic [CountBits-1:0] wr_data_i,
  output logic                      busy_o
);

  logic [CountBits-1:0] mem_q [Depth];
  logic [CountBits-1:0] rd_data_q;
  logic                 clr_q;
  logic                 clr_d;
  logic [AddrW-1:0]     clr_addr_q;
  logic [AddrW-1:0]     clr_addr_d;

  // Clearing sweep after reset, one entry per cycle.
  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Memory array: the sweep owns the write port while it runs.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clr_q;

endmodule

`default_nettype wire

### bench/lossless_predictor_residual_histogram_unit_test.sv
// Self-checking bench for the predictor residual histogram unit: residuals and bin reads.
module lossless_predictor_residual_histogram_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lprh_pkg::*;

  localparam int CHANNELS   = 3;
  localparam int COUNT_BITS = 32;
  localparam longint unsigned CountMax    = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned OutCountMax = 64'hFFFF_FFFF;
  localparam int RandomBeats = 1100;
  // Long output stall that lets the unit fill up and push back on its input.
  localparam int HoldAt  = 200;
  localparam int HoldLen = 500;
  // The clearing pass after reset alone counts as quiet.
  localparam int QuietLimit = 30000;

  logic clk_i;
  logic rst_ni;

  lprh_in_if  in_bus ();
  lprh_out_if out_bus ();

  lossless_predictor_residual_histogram_unit #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Shadow copy of the counter memory and the stimulus and prediction queues.
  longint unsigned bin_counts [CHANNELS][HistPerCh][Bins];
  in_item_t        sample_beats_q[$];
  out_item_t       residual_count_q[$];

  int unsigned beats_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned total_beats   = 0;
  int unsigned mismatches    = 0;
  int unsigned quiet_cycles  = 0;
  int          gap_left;
  int          stall_left;

  // Saturating increment of one shadow counter.
  function automatic void bump_bin(int ch, int hist, logic [7:0] bin);
    if (bin_counts[ch][hist][bin] < CountMax) begin
      bin_counts[ch][hist][bin] = bin_counts[ch][hist][bin] + 64'd1;
    end
  endfunction

  // Computes the result of one beat and updates the shadow histograms.
  function automatic out_item_t predict_residuals(input in_item_t beat);
    int              nw_v, n_v, w_v, s_v, lo, hi;
    int              guess [8];
    res_vec_t        res;
    longint unsigned total;
    out_item_t       r;
    r = '0;
    nw_v = beat.nw;
    n_v  = beat.n;
    w_v  = beat.w;
    s_v  = beat.sample;
    if (beat.operation == OP_ACCUM) begin
      guess[0] = w_v;
      guess[1] = n_v;
      guess[2] = nw_v;
      guess[3] = (w_v + n_v - nw_v) & 255;
      // Integer division truncates toward zero, as the predictor requires.
      guess[4] = (n_v + (w_v - nw_v) / 2) & 255;
      guess[5] = (w_v + (n_v - nw_v) / 2) & 255;
      guess[6] = (n_v + w_v) / 2;
      lo = (n_v < w_v) ? n_v : w_v;
      hi = (n_v < w_v) ? w_v : n_v;
      if (nw_v >= hi) begin
        guess[7] = lo;
      end else if (nw_v <= lo) begin
        guess[7] = hi;
      end else begin
        guess[7] = guess[3];
      end
      for (int k = 0; k < 8; k++) begin
        res[k] = 8'(s_v - guess[k]);
      end
      // A channel outside the store still yields residuals but counts nothing.
      if (beat.channel < CHANNELS) begin
        bump_bin(beat.channel, 0, beat.sample);
        for (int k = 0; k < 8; k++) begin
          bump_bin(beat.channel, k + 1, res[k]);
        end
      end
      r.res_west       = res[0];
      r.res_north      = res[1];
      r.res_northwest  = res[2];
      r.res_plane      = res[3];
      r.res_half_west  = res[4];
      r.res_half_north = res[5];
      r.res_average    = res[6];
      r.res_median     = res[7];
    end else begin
      total = 0;
      if (beat.read_predictor < HistPerCh) begin
        if (beat.read_table == TableSum) begin
          for (int t = 0; t < CHANNELS; t++) begin
            total = total + bin_counts[t][beat.read_predictor][beat.read_bin];
            if (total > CountMax) total = CountMax;
          end
        end else if (beat.read_table < CHANNELS) begin
          total = bin_counts[beat.read_table][beat.read_predictor][beat.read_bin];
        end
      end
      if (total > OutCountMax) total = OutCountMax;
      r.count = total[OutCountW-1:0];
    end
    return r;
  endfunction

  function automatic in_item_t accum_beat(int nw, int n, int w, int s, int ch);
    in_item_t b;
    b.operation      = OP_ACCUM;
    b.nw             = 8'(nw);
    b.n              = 8'(n);
    b.w              = 8'(w);
    b.sample         = 8'(s);
    b.channel        = 2'(ch);
    // Read fields carry noise; the unit must ignore them here.
    b.read_predictor = 4'($urandom_range(0, 15));
    b.read_table     = 2'($urandom_range(0, 3));
    b.read_bin       = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic in_item_t read_beat(int hist, int tbl, int bin);
    in_item_t b;
    b.operation      = OP_READ;
    b.nw             = 8'($urandom_range(0, 255));
    b.n              = 8'($urandom_range(0, 255));
    b.w              = 8'($urandom_range(0, 255));
    b.sample         = 8'($urandom_range(0, 255));
    b.channel        = 2'($urandom_range(0, 3));
    b.read_predictor = 4'(hist);
    b.read_table     = 2'(tbl);
    b.read_bin       = 8'(bin);
    return b;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Input driver: presents queued beats with a random gap after each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    int gap;
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.payload <= '0;
      gap_left       <= 0;
    end else if (in_bus.valid && in_bus.ready) begin
      residual_count_q.push_back(predict_residuals(in_bus.payload));
      beats_sent++;
      // Every third stretch of 80 beats is sent back to back.
      gap = ((beats_sent / 80) % 3 == 2) ? 0 : $urandom_range(0, 7);
      if (gap == 0 && sample_beats_q.size() != 0) begin
        in_bus.payload <= sample_beats_q.pop_front();
      end else begin
        in_bus.valid <= 1'b0;
        gap_left     <= gap;
      end
    end else if (!in_bus.valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (sample_beats_q.size() != 0) begin
        in_bus.payload <= sample_beats_q.pop_front();
        in_bus.valid   <= 1'b1;
      end
    end
  end

  // Output monitor: checks each result beat and stalls ready at random.
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    out_item_t want;
    int        stall;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left    <= 1;
    end else if (out_bus.valid && out_bus.ready) begin
      if (residual_count_q.size() == 0) begin
        $error("result beat arrived with no prediction waiting");
        mismatches++;
      end else begin
        want = residual_count_q.pop_front();
        check_field("res_west", want.res_west, out_bus.payload.res_west);
        check_field("res_north", want.res_north, out_bus.payload.res_north);
        check_field("res_northwest", want.res_northwest, out_bus.payload.res_northwest);
        check_field("res_plane", want.res_plane, out_bus.payload.res_plane);
        check_field("res_half_west", want.res_half_west, out_bus.payload.res_half_west);
        check_field("res_half_north", want.res_half_north, out_bus.payload.res_half_north);
        check_field("res_average", want.res_average, out_bus.payload.res_average);
        check_field("res_median", want.res_median, out_bus.payload.res_median);
        check_field("count", want.count, out_bus.payload.count);
      end
      beats_checked++;
      if (beats_checked == HoldAt) begin
        stall = HoldLen;
      end else if ((beats_checked / 60) % 3 == 1) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        stall_left    <= stall;
      end
    end else if (!out_bus.ready) begin
      if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int       base, hist, last_sample;
    in_item_t b;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.payload = '0;
    out_bus.ready  = 1'b0;
    foreach (bin_counts[c, p, k]) bin_counts[c][p][k] = 0;

    // Directed part: field extremes and the median and rounding corner cases.
    sample_beats_q.push_back(accum_beat(0, 0, 0, 0, 0));
    sample_beats_q.push_back(accum_beat(255, 255, 255, 255, 1));
    // North-west above both neighbors: the median picks the smaller one.
    sample_beats_q.push_back(accum_beat(255, 0, 0, 0, 2));
    // North-west below both neighbors: the median picks the larger one.
    sample_beats_q.push_back(accum_beat(0, 255, 128, 255, 0));
    // North-west between the neighbors: the median falls back to the plane.
    sample_beats_q.push_back(accum_beat(100, 150, 50, 77, 1));
    // Odd negative differences check truncation toward zero.
    sample_beats_q.push_back(accum_beat(10, 7, 3, 0, 2));
    // Plane prediction wraps past 255.
    sample_beats_q.push_back(accum_beat(0, 255, 255, 0, 0));
    // Channel outside the store: residuals only.
    sample_beats_q.push_back(accum_beat(255, 0, 255, 128, 3));
    sample_beats_q.push_back(accum_beat(1, 2, 3, 0, 0));
    sample_beats_q.push_back(read_beat(0, 0, 0));
    sample_beats_q.push_back(read_beat(0, TableSum, 0));
    sample_beats_q.push_back(read_beat(0, 1, 255));
    sample_beats_q.push_back(read_beat(1, 2, 0));
    sample_beats_q.push_back(read_beat(8, TableSum, 0));
    sample_beats_q.push_back(read_beat(9, 0, 0));
    sample_beats_q.push_back(read_beat(15, TableSum, 255));
    sample_beats_q.push_back(read_beat(0, TableSum, 128));
    sample_beats_q.push_back(read_beat(4, 0, 255));
    sample_beats_q.push_back(accum_beat(0, 0, 0, 0, 1));
    sample_beats_q.push_back(read_beat(0, TableSum, 0));
    sample_beats_q.push_back(read_beat(7, 2, 255));

    // Random part: mostly smooth image-like samples, reads aimed at busy bins.
    last_sample = 0;
    for (int i = 0; i < RandomBeats; i++) begin
      if ($urandom_range(0, 99) < 65) begin
        if ($urandom_range(0, 9) < 7) begin
          base = $urandom_range(0, 255);
          b = accum_beat(base + $urandom_range(0, 8) - 4, base + $urandom_range(0, 8) - 4,
                         base + $urandom_range(0, 8) - 4, base + $urandom_range(0, 8) - 4,
                         ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2));
        end else begin
          b = accum_beat($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 3));
        end
        last_sample = b.sample;
      end else begin
        hist = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        if ($urandom_range(0, 1) == 0) begin
          b = read_beat(hist, $urandom_range(0, 3), $urandom_range(0, 255));
        end else if (hist == 0) begin
          b = read_beat(hist, $urandom_range(0, 3), last_sample);
        end else begin
          b = read_beat(hist, $urandom_range(0, 3), ($urandom_range(0, 8) - 4) & 255);
        end
      end
      sample_beats_q.push_back(b);
    end
    total_beats = sample_beats_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_sent < total_beats || residual_count_q.size() != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
design/lprh_pkg.sv
design/lprh_if.sv
design/lprh_predict.sv
design/lprh_store.sv
design/lossless_predictor_residual_histogram_unit.sv
bench/lossless_predictor_residual_histogram_unit_test.sv
